@@ src/assert_macros.svh @@
// Assertion macros used by the escape-time unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, held off during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ src/mbe_pkg.sv @@
// Package: widths, register indexes and item types of the escape-time unit.
package mbe_pkg;

   localparam int COORD_WIDTH   = 32;
   localparam int FRACTION_BITS = 24;
   localparam int LIMIT_WIDTH   = 16;
   localparam int RADIUS_WIDTH  = 4;

   // z before squaring never exceeds the radius, so it fits in this signed width
   localparam int Z_WIDTH    = FRACTION_BITS + RADIUS_WIDTH + 1;
   localparam int PROD_WIDTH = 2 * Z_WIDTH + 1;
   localparam int SHIFT_WIDTH = PROD_WIDTH - FRACTION_BITS;
   localparam int SUM_WIDTH  = ((SHIFT_WIDTH > COORD_WIDTH) ? SHIFT_WIDTH : COORD_WIDTH) + 1;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = LIMIT_WIDTH;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ITERATION_LIMIT = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ESCAPE_RADIUS   = 1'b1;

   localparam logic [LIMIT_WIDTH-1:0]  RESET_LIMIT  = 16'd100;
   localparam logic [RADIUS_WIDTH-1:0] RESET_RADIUS = 4'd10;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] c_real;
      logic signed [COORD_WIDTH-1:0] c_imag;
      logic                          frame_start;
   } mbe_req_type;

   typedef struct packed {
      logic [LIMIT_WIDTH-1:0] escape_count;
      logic                   escaped;
      logic [LIMIT_WIDTH-1:0] frame_max_count;
   } mbe_rsp_type;

endpackage

@@ src/mandelbrot_escape_time_unit.sv @@
// Mandelbrot escape-time unit: iterates z = z*z + c through one shared multiplier.
//
// One point is taken at a time. Each iteration runs four steps: a z update
// with the component bound test, then zr*zr, zi*zi and zr*zi through the one
// signed multiplier; the two squares also give the |z|^2 test of the fresh z.
// A point ends when z escapes the radius or the iteration limit is reached,
// and a zero limit goes straight to the result. The unit returns to idle
// before the next point is taken, so the cost is set by the iteration limit
// and that four-step multiplier loop. The result sits in an output register,
// so the next point may start while it waits to be taken.
`include "assert_macros.svh"

module mandelbrot_escape_time_unit
   import mbe_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  mbe_req_type                req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output mbe_rsp_type                rsp_payload,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_UPD,
      S_RR,
      S_II,
      S_RI,
      S_DONE
   } state_type;

   state_type state_ff;

   logic [LIMIT_WIDTH-1:0]  limit_ff;
   logic [RADIUS_WIDTH-1:0] radius_ff;
   logic [LIMIT_WIDTH-1:0]  max_ff;

   logic signed [COORD_WIDTH-1:0] cr_ff, ci_ff;
   logic                          frame_ff;
   logic signed [Z_WIDTH-1:0]     zr_ff, zi_ff;
   logic signed [2*Z_WIDTH-1:0]   rr_ff, ii_ff, ri_ff;
   logic [LIMIT_WIDTH-1:0]        it_ff;
   logic [LIMIT_WIDTH-1:0]        count_ff;
   logic                          esc_ff;

   logic        rsp_valid_ff;
   mbe_rsp_type rsp_ff;

   // shared multiplier
   logic signed [Z_WIDTH-1:0]   mul_a, mul_b;
   logic signed [2*Z_WIDTH-1:0] mul_p;

   always_comb begin
      case (state_ff)
         S_RR: begin
            mul_a = zr_ff;
            mul_b = zr_ff;
         end
         S_II: begin
            mul_a = zi_ff;
            mul_b = zi_ff;
         end
         default: begin
            mul_a = zr_ff;
            mul_b = zi_ff;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // z update: floor shift of the products, then add c
   logic signed [PROD_WIDTH-1:0] sq_re, sq_im, sh_re, sh_im;
   logic signed [SUM_WIDTH-1:0]  new_re, new_im, rad_fix;
   logic                         out_of_bound;

   assign sq_re  = PROD_WIDTH'(rr_ff) - PROD_WIDTH'(ii_ff);
   assign sq_im  = PROD_WIDTH'(ri_ff) <<< 1;
   assign sh_re  = sq_re >>> FRACTION_BITS;
   assign sh_im  = sq_im >>> FRACTION_BITS;
   assign new_re = SUM_WIDTH'(sh_re) + SUM_WIDTH'(cr_ff);
   assign new_im = SUM_WIDTH'(sh_im) + SUM_WIDTH'(ci_ff);
   assign rad_fix = signed'(SUM_WIDTH'({radius_ff, {FRACTION_BITS{1'b0}}}));
   assign out_of_bound = (new_re > rad_fix) || (new_re < -rad_fix) ||
                         (new_im > rad_fix) || (new_im < -rad_fix);

   // |z|^2 against radius^2
   logic [2*RADIUS_WIDTH-1:0] rad_sq_int;
   logic [2*Z_WIDTH:0]        mag_sq, rad_sq;
   logic                      mag_escape;

   assign rad_sq_int = {{RADIUS_WIDTH{1'b0}}, radius_ff} * {{RADIUS_WIDTH{1'b0}}, radius_ff};
   assign rad_sq     = (2*Z_WIDTH+1)'({rad_sq_int, {(2*FRACTION_BITS){1'b0}}});
   assign mag_sq     = {1'b0, rr_ff} + {1'b0, ii_ff};
   assign mag_escape = mag_sq > rad_sq;

   logic last_iter;
   assign last_iter = ((LIMIT_WIDTH+1)'(it_ff) + (LIMIT_WIDTH+1)'(1))
                      == (LIMIT_WIDTH+1)'(limit_ff);

   logic [LIMIT_WIDTH-1:0] max_base, max_new;
   assign max_base = frame_ff ? '0 : max_ff;
   assign max_new  = (count_ff > max_base) ? count_ff : max_base;

   logic req_accept;
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         max_ff       <= '0;
         limit_ff     <= RESET_LIMIT;
         radius_ff    <= RESET_RADIUS;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_ITERATION_LIMIT: limit_ff  <= csr_write_data;
               CSR_ESCAPE_RADIUS:   radius_ff <= csr_write_data[RADIUS_WIDTH-1:0];
               default: ;
            endcase
         end

         // drop the result once taken, unless a fresh one replaces it
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  cr_ff    <= req_payload.c_real;
                  ci_ff    <= req_payload.c_imag;
                  frame_ff <= req_payload.frame_start;
                  rr_ff    <= '0;
                  ii_ff    <= '0;
                  ri_ff    <= '0;
                  it_ff    <= '0;
                  count_ff <= '0;
                  esc_ff   <= 1'b0;
                  state_ff <= (limit_ff == '0) ? S_DONE : S_UPD;
               end
            end
            S_UPD: begin
               if (out_of_bound) begin
                  count_ff <= it_ff;
                  esc_ff   <= 1'b1;
                  state_ff <= S_DONE;
               end else begin
                  zr_ff    <= Z_WIDTH'(new_re);
                  zi_ff    <= Z_WIDTH'(new_im);
                  state_ff <= S_RR;
               end
            end
            S_RR: begin
               rr_ff    <= mul_p;
               state_ff <= S_II;
            end
            S_II: begin
               ii_ff    <= mul_p;
               state_ff <= S_RI;
            end
            S_RI: begin
               ri_ff <= mul_p;
               if (mag_escape) begin
                  count_ff <= it_ff;
                  esc_ff   <= 1'b1;
                  state_ff <= S_DONE;
               end else if (last_iter) begin
                  state_ff <= S_DONE;
               end else begin
                  it_ff    <= it_ff + 1'b1;
                  state_ff <= S_UPD;
               end
            end
            S_DONE: begin
               // hold until the output register is free
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_ff.escape_count    <= count_ff;
                  rsp_ff.escaped         <= esc_ff;
                  rsp_ff.frame_max_count <= max_new;
                  max_ff                 <= max_new;
                  rsp_valid_ff           <= 1'b1;
                  state_ff               <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_accept, state_ff != S_IDLE)
   `ASSERT_IMPLY(a_iter_in_range, clock, reset,
      (state_ff == S_UPD) || (state_ff == S_RR) || (state_ff == S_II) || (state_ff == S_RI),
      it_ff < limit_ff)
   `ASSERT_IMPLY(a_no_escape_zero, clock, reset, rsp_valid_ff && !rsp_ff.escaped,
      rsp_ff.escape_count == '0)
   `ASSERT_IMPLY(a_max_covers_count, clock, reset, rsp_valid_ff,
      rsp_ff.frame_max_count >= rsp_ff.escape_count)

endmodule

@@ bench/tb_mandelbrot_escape_time_unit.sv @@
// Self-checking testbench for the Mandelbrot escape-time unit: directed and random points.
module tb_mandelbrot_escape_time_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import mbe_pkg::*;

   localparam int WATCHDOG_LIMIT   = 1_200_000;
   localparam int MISMATCH_REPORTS = 10;
   localparam int RANDOM_ITEMS     = 1830;

   // Expected results of accepted points, with a private copy of the registers
   // and of the per-frame peak count.
   class escape_ledger;
      logic [LIMIT_WIDTH-1:0]  limit;
      logic [RADIUS_WIDTH-1:0] radius;
      logic [LIMIT_WIDTH-1:0]  frame_peak;
      mbe_rsp_type             awaited[$];
      int unsigned             mismatches;

      function new();
         limit      = RESET_LIMIT;
         radius     = RESET_RADIUS;
         frame_peak = '0;
         mismatches = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_WIDTH-1:0] idx,
                                   logic [CSR_DATA_WIDTH-1:0] data);
         case (idx)
            CSR_ITERATION_LIMIT: limit = data;
            CSR_ESCAPE_RADIUS:   radius = data[RADIUS_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      function mbe_rsp_type predict_escape(mbe_req_type p);
         longint cre, cim, zre, zim, sq_re, sq_im, are, aim, rad_fixed, rad_sq;
         int iter;
         logic [LIMIT_WIDTH-1:0] count;
         logic esc;
         mbe_rsp_type r;
         cre       = longint'(p.c_real);
         cim       = longint'(p.c_imag);
         rad_fixed = longint'(radius) << FRACTION_BITS;
         rad_sq    = (longint'(radius) * longint'(radius)) << (2 * FRACTION_BITS);
         zre   = 0;
         zim   = 0;
         count = '0;
         esc   = 1'b0;
         if (p.frame_start)
            frame_peak = '0;
         for (iter = 0; iter < int'(limit) && !esc; iter++) begin
            sq_re = zre * zre - zim * zim;
            sq_im = 2 * zre * zim;
            // arithmetic shift floors, as the datapath does
            zre = (sq_re >>> FRACTION_BITS) + cre;
            zim = (sq_im >>> FRACTION_BITS) + cim;
            are = (zre < 0) ? -zre : zre;
            aim = (zim < 0) ? -zim : zim;
            // test components first so the squares never overflow
            if (are > rad_fixed || aim > rad_fixed)
               esc = 1'b1;
            else if (are * are + aim * aim > rad_sq)
               esc = 1'b1;
            if (esc)
               count = iter[LIMIT_WIDTH-1:0];
         end
         if (count > frame_peak)
            frame_peak = count;
         r.escape_count    = count;
         r.escaped         = esc;
         r.frame_max_count = frame_peak;
         return r;
      endfunction

      function void note_point(mbe_req_type p);
         awaited.insert(awaited.size(), predict_escape(p));
      endfunction

      function void check_result(mbe_rsp_type got);
         mbe_rsp_type want;
         logic bad;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= MISMATCH_REPORTS)
               $display("tb: result with nothing awaited: count=%0d escaped=%0b max=%0d",
                        got.escape_count, got.escaped, got.frame_max_count);
            return;
         end
         want = awaited.pop_front();
         bad = (got.escape_count !== want.escape_count) ||
               (got.escaped !== want.escaped) ||
               (got.frame_max_count !== want.frame_max_count);
         if (bad) begin
            mismatches++;
            if (mismatches <= MISMATCH_REPORTS)
               $display("tb: mismatch: expected count=%0d escaped=%0b max=%0d,",
                        want.escape_count, want.escaped, want.frame_max_count,
                        " got count=%0d escaped=%0b max=%0d",
                        got.escape_count, got.escaped, got.frame_max_count);
         end
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   mbe_req_type                req_payload;
   logic                       rsp_valid;
   logic                       rsp_stall;
   mbe_rsp_type                rsp_payload;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   escape_ledger ledger = new();
   int idle_cycles = 0;
   int stall_hold  = 0;
   int stall_mode  = 0;
   int burst_left  = 0;
   int frame_left  = 0;

   mandelbrot_escape_time_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Receiver: stretches of solid stall, free running and random chatter.
   always @(posedge clock) begin
      if (stall_hold == 0) begin
         stall_mode = $urandom_range(0, 9);
         if (stall_mode < 2) begin
            rsp_stall  <= 1'b1;
            stall_hold = $urandom_range(1, 40);
         end else if (stall_mode < 4) begin
            rsp_stall  <= 1'b0;
            stall_hold = $urandom_range(50, 200);
         end else begin
            rsp_stall  <= 1'($urandom_range(0, 1));
            stall_hold = $urandom_range(1, 6);
         end
      end else begin
         stall_hold--;
      end
   end

   // Check results and watch for a hung handshake.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            ledger.check_result(rsp_payload);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   function automatic mbe_req_type make_point(int re, int im, bit fs);
      mbe_req_type p;
      p.c_real      = re;
      p.c_imag      = im;
      p.frame_start = fs;
      return p;
   endfunction

   // Mostly points around the set, grouped into frames; some full-range noise.
   function automatic mbe_req_type random_point(bit fast_only);
      mbe_req_type p;
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
         p.c_real = $urandom_range(0, 32'h0400_0000) - 32'h0280_0000;
         p.c_imag = $urandom_range(0, 32'h0300_0000) - 32'h0180_0000;
      end else begin
         p.c_real = $urandom;
         p.c_imag = $urandom;
      end
      // with a huge limit, push small points far out so they escape at once
      if (fast_only &&
          ((p.c_real >>> 26) == 0 || (p.c_real >>> 26) == -1) &&
          ((p.c_imag >>> 26) == 0 || (p.c_imag >>> 26) == -1))
         p.c_real[30] = ~p.c_real[30];
      if (frame_left == 0) begin
         p.frame_start = 1'b1;
         frame_left    = $urandom_range(1, 30);
      end else begin
         p.frame_start = ($urandom_range(0, 19) == 0);
      end
      frame_left--;
      return p;
   endfunction

   task automatic set_limits(input logic [CSR_DATA_WIDTH-1:0] limit_value,
                             input logic [CSR_DATA_WIDTH-1:0] radius_value);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_ITERATION_LIMIT;
      csr_write_data   <= limit_value;
      @(posedge clock);
      ledger.write_register(CSR_ITERATION_LIMIT, limit_value);
      csr_index      <= CSR_ESCAPE_RADIUS;
      csr_write_data <= radius_value;
      @(posedge clock);
      ledger.write_register(CSR_ESCAPE_RADIUS, radius_value);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_point(input mbe_req_type p);
      req_valid   <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      ledger.note_point(p);
   endtask

   task automatic send_paced(input mbe_req_type p);
      int gap;
      send_point(p);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(0, 24);
      end
   endtask

   // Hold the sender off until every awaited result has been taken.
   task automatic drain();
      req_valid <= 1'b0;
      while (ledger.outstanding() != 0)
         @(posedge clock);
   endtask

   initial begin
      int sent, phase_len, sel, tail_cycles;
      logic [CSR_DATA_WIDTH-1:0] limit_data, radius_data;
      logic [RADIUS_WIDTH-1:0] radius_pick;
      bit fast_only;

      req_valid        <= 1'b0;
      req_payload      <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_ITERATION_LIMIT;
      csr_write_data   <= '0;
      reset            <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // register values straight after reset
      send_point(make_point(0, 0, 1'b1));
      send_point(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
      send_point(make_point(32'h8000_0000, 32'h8000_0000, 1'b0));
      send_point(make_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
      send_point(make_point(32'h0133_3333, 0, 1'b0));
      send_point(make_point(32'h0060_0000, 0, 1'b0));
      send_point(make_point(32'hFE00_0000, 0, 1'b0));
      send_point(make_point(0, 32'h0100_0000, 1'b1));
      drain();

      // no iterations at all
      set_limits(16'h0000, 16'h000A);
      send_point(make_point(32'h7FFF_FFFF, 0, 1'b0));
      send_point(make_point(0, 0, 1'b1));
      drain();

      // widest limit and radius; a point just past the cusp escapes slowly
      set_limits(16'hFFFF, 16'hFFFF);
      send_point(make_point(32'h0040_0001, 0, 1'b1));
      send_point(make_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
      send_point(make_point(32'h0100_0000, 0, 1'b0));
      send_point(make_point(0, 0, 1'b1));
      drain();

      // zero radius: any nonzero z escapes
      set_limits(16'h0001, 16'hFFF0);
      send_point(make_point(0, 0, 1'b0));
      send_point(make_point(1, 0, 1'b0));
      send_point(make_point(0, -1, 1'b1));
      drain();

      // radius 2: escape by |z|^2 alone, and exactly on the radius
      set_limits(16'd20, 16'h0002);
      send_point(make_point(32'h0180_0000, 32'h0180_0000, 1'b0));
      send_point(make_point(32'h0200_0000, 0, 1'b0));
      send_point(make_point(32'hFE00_0000, 0, 1'b0));
      send_point(make_point(32'h0200_0001, 0, 1'b0));
      drain();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         sel       = $urandom_range(0, 19);
         fast_only = 1'b0;
         if (sel == 0)
            limit_data = 16'h0000;
         else if (sel == 1)
            limit_data = 16'h0001;
         else if (sel == 2) begin
            limit_data = 16'hFFFF;
            fast_only  = 1'b1;
         end else if (sel < 13)
            limit_data = CSR_DATA_WIDTH'($urandom_range(2, 40));
         else
            limit_data = CSR_DATA_WIDTH'($urandom_range(41, 300));
         radius_pick = RADIUS_WIDTH'($urandom_range(0, 15));
         radius_data = {(CSR_DATA_WIDTH-RADIUS_WIDTH)'($urandom_range(0, 12'hFFF)),
                        radius_pick};
         set_limits(limit_data, radius_data);
         phase_len = $urandom_range(40, 110);
         frame_left = 0;
         repeat (phase_len) begin
            send_paced(random_point(fast_only));
            sent++;
         end
         drain();
      end

      // wait out a tail for any stray result before the verdict
      tail_cycles = (ledger.limit > 16'd1000) ? 4016 : 4 * int'(ledger.limit) + 16;
      repeat (tail_cycles) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.outstanding() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+src
src/mbe_pkg.sv
src/mandelbrot_escape_time_unit.sv
bench/tb_mandelbrot_escape_time_unit.sv
